@@ rtl/qau_pkg.sv @@
`timescale 1ns / 1ps

package qau_pkg;

	// Operation codes carried on the func field of a request.
	typedef enum logic [2:0] {
		OP_MUL   = 3'd0,
		OP_ROT   = 3'd1,
		OP_CONJ  = 3'd2,
		OP_SCALE = 3'd3,
		OP_DIV   = 3'd4,
		OP_MAG   = 3'd5,
		OP_NORM  = 3'd6
	} op_t;

endpackage

@@ rtl/quaternion_arithmetic_unit_top.sv @@
`timescale 1ns / 1ps

// Channel   | valid     | stall     | payload
// ----------+-----------+-----------+-----------------------------------------------
// request   | req_valid | req_stall | func, a_w..a_z, b_w..b_z, scalar
// response  | rsp_valid | rsp_stall | r_w..r_z, div_by_zero, saturated
//
// One request is taken in every cycle while req_stall is low; every operation passes through the
// same stages alike.
// The pipeline length is set by the square root and divider chains, which resolve one bit per stage.
// Reset clears only the valid bits of the stages and of the output register.
// While a result waits in the output register and rsp_stall is high, every stage holds and
// req_stall is raised; nothing is dropped or repeated.

module quaternion_arithmetic_unit_top
	import qau_pkg::*;
#(
	parameter int FRAC_BITS  = 14,
	parameter int COMP_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [2:0]                   func,
	input  logic signed [COMP_WIDTH-1:0] a_w,
	input  logic signed [COMP_WIDTH-1:0] a_x,
	input  logic signed [COMP_WIDTH-1:0] a_y,
	input  logic signed [COMP_WIDTH-1:0] a_z,
	input  logic signed [COMP_WIDTH-1:0] b_w,
	input  logic signed [COMP_WIDTH-1:0] b_x,
	input  logic signed [COMP_WIDTH-1:0] b_y,
	input  logic signed [COMP_WIDTH-1:0] b_z,
	input  logic signed [COMP_WIDTH-1:0] scalar,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic signed [COMP_WIDTH-1:0] r_w,
	output logic signed [COMP_WIDTH-1:0] r_x,
	output logic signed [COMP_WIDTH-1:0] r_y,
	output logic signed [COMP_WIDTH-1:0] r_z,
	output logic                         div_by_zero,
	output logic                         saturated
);

	localparam int W   = COMP_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * W;           // one product
	localparam int AW  = 2 * W + 3;       // sum of four products plus rounding
	localparam int SSW = 2 * W + 1;       // sum of squares
	localparam int RB  = W + 1;           // square root bits
	localparam int RMW = 2 * W + 3;       // square root remainder
	localparam int NW  = W + F + 2;       // divider numerator 2*a*2^F + den
	localparam int QB  = W + 1;           // quotient bits kept below the overflow bit
	localparam int DW  = ((NW > 2 * W + 3) ? NW : 2 * W + 3) + 1;
	localparam int VW  = W + 3;           // signed quotient after rounding

	localparam logic signed [AW-1:0] CMAX_A = AW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] CMIN_A = ~CMAX_A;
	localparam logic signed [AW-1:0] HALF_A = AW'(64'sd1 <<< (F - 1));
	localparam logic signed [VW-1:0] CMAX_V = VW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [VW-1:0] CMIN_V = ~CMAX_V;
	localparam logic signed [W-1:0]  CMAX_W = {1'b0, {(W - 1){1'b1}}};
	localparam logic signed [W-1:0]  CMIN_W = {1'b1, {(W - 1){1'b0}}};

	// The item as it travels from the fourth stage onwards. r and fl hold the finished
	// result for every operation that does not need the divider.
	typedef struct packed {
		op_t                 op;
		logic [3:0][W-1:0]   a;
		logic [W-1:0]        sc;
		logic [3:0][W-1:0]   r;
		logic                fl;
		logic [RB-1:0]       m;
	} item_t;

	// Rounds a Q(2F) sum to Q(F) with ties upwards and clips it; the top bit is the clip flag.
	function automatic logic [W:0] rnd_sat(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] rs;
		rs = (v + HALF_A) >>> F;
		if (rs > CMAX_A) begin
			return {1'b1, CMAX_W};
		end else if (rs < CMIN_A) begin
			return {1'b1, CMIN_W};
		end
		return {1'b0, rs[W-1:0]};
	endfunction

	function automatic logic [W:0] sat_v(input logic signed [VW-1:0] v);
		if (v > CMAX_V) begin
			return {1'b1, CMAX_W};
		end else if (v < CMIN_V) begin
			return {1'b1, CMIN_W};
		end
		return {1'b0, v[W-1:0]};
	endfunction

	// The whole pipeline moves together; it only holds when the output register is full
	// and the far side stalls it.
	logic en;
	logic vo_q;

	assign en        = !(vo_q && rsp_stall);
	assign req_stall = !en;

	logic signed [W-1:0] ain [4];
	logic signed [W-1:0] bin [4];

	assign ain[0] = a_w;
	assign ain[1] = a_x;
	assign ain[2] = a_y;
	assign ain[3] = a_z;
	assign bin[0] = b_w;
	assign bin[1] = b_x;
	assign bin[2] = b_y;
	assign bin[3] = b_z;

	// Stage 1: products of the inner rotation product b*conj(a), and the squares of a.
	logic                v_s1;
	op_t                 op_s1;
	logic [3:0][W-1:0]   a_s1;
	logic [3:0][W-1:0]   b_s1;
	logic [W-1:0]        sc_s1;
	logic signed [PW-1:0] p_s1  [4][4];
	logic signed [PW-1:0] sq_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op_t'(func);
			sc_s1 <= scalar;
			for (int i = 0; i < 4; i++) begin
				a_s1[i]  <= ain[i];
				b_s1[i]  <= bin[i];
				sq_s1[i] <= ain[i] * ain[i];
				for (int j = 0; j < 4; j++) begin
					p_s1[i][j] <= bin[i] * ain[j];
				end
			end
		end
	end

	// Stage 2: the inner product rounded and clipped, and the sum of squares.
	logic                v_s2;
	op_t                 op_s2;
	logic [3:0][W-1:0]   a_s2;
	logic [3:0][W-1:0]   b_s2;
	logic [W-1:0]        sc_s2;
	logic [3:0][W-1:0]   t_s2;
	logic                tfl_s2;
	logic [SSW-1:0]      ss_s2;

	logic signed [AW-1:0] e1 [4][4];
	logic [W:0]           t_rs [4];
	logic [SSW-1:0]       ssum;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				e1[i][j] = AW'(p_s1[i][j]);
			end
		end
		t_rs[0] = rnd_sat(e1[0][0] + e1[1][1] + e1[2][2] + e1[3][3]);
		t_rs[1] = rnd_sat(-e1[0][1] + e1[1][0] - e1[2][3] + e1[3][2]);
		t_rs[2] = rnd_sat(-e1[0][2] + e1[1][3] + e1[2][0] - e1[3][1]);
		t_rs[3] = rnd_sat(-e1[0][3] - e1[1][2] + e1[2][1] + e1[3][0]);
		ssum = SSW'($unsigned(sq_s1[0])) + SSW'($unsigned(sq_s1[1]))
			+ SSW'($unsigned(sq_s1[2])) + SSW'($unsigned(sq_s1[3]));
		// With components of 32 bits or more, a sum with its top bit set is clipped below that bit.
		if (SSW > 64 && ssum[SSW-1]) begin
			ssum = {1'b0, {(SSW - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= op_s1;
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			sc_s2  <= sc_s1;
			ss_s2  <= ssum;
			tfl_s2 <= t_rs[0][W] | t_rs[1][W] | t_rs[2][W] | t_rs[3][W];
			for (int k = 0; k < 4; k++) begin
				t_s2[k] <= t_rs[k][W-1:0];
			end
		end
	end

	// Stage 3: products of the outer product a*r, where r is the inner product for a
	// rotation and b otherwise, and the scaled components.
	logic                v_s3;
	op_t                 op_s3;
	logic [3:0][W-1:0]   a_s3;
	logic [W-1:0]        sc_s3;
	logic                tfl_s3;
	logic [SSW-1:0]      ss_s3;
	logic signed [PW-1:0] q_s3   [4][4];
	logic signed [PW-1:0] scp_s3 [4];

	logic [3:0][W-1:0]   rsel;

	assign rsel = (op_s2 == OP_ROT) ? t_s2 : b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3  <= op_s2;
			a_s3   <= a_s2;
			sc_s3  <= sc_s2;
			tfl_s3 <= tfl_s2;
			ss_s3  <= ss_s2;
			for (int i = 0; i < 4; i++) begin
				scp_s3[i] <= $signed(a_s2[i]) * $signed(sc_s2);
				for (int j = 0; j < 4; j++) begin
					q_s3[i][j] <= $signed(a_s2[i]) * $signed(rsel[j]);
				end
			end
		end
	end

	// Stage 4: the results of product, rotation, conjugate and scale are finished here.
	logic                v_s4;
	item_t               c_s4;
	logic [SSW-1:0]      ss_s4;

	logic signed [AW-1:0] e3 [4][4];
	logic [W:0]           o_rs  [4];
	logic [W:0]           sc_rs [4];
	item_t                c4;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				e3[i][j] = AW'(q_s3[i][j]);
			end
			sc_rs[i] = rnd_sat(AW'(scp_s3[i]));
		end
		o_rs[0] = rnd_sat(e3[0][0] - e3[1][1] - e3[2][2] - e3[3][3]);
		o_rs[1] = rnd_sat(e3[0][1] + e3[1][0] + e3[2][3] - e3[3][2]);
		o_rs[2] = rnd_sat(e3[0][2] - e3[1][3] + e3[2][0] + e3[3][1]);
		o_rs[3] = rnd_sat(e3[0][3] + e3[1][2] - e3[2][1] + e3[3][0]);

		c4    = '0;
		c4.op = op_s3;
		c4.a  = a_s3;
		c4.sc = sc_s3;
		case (op_s3)
			OP_MUL, OP_ROT: begin
				for (int k = 0; k < 4; k++) begin
					c4.r[k] = o_rs[k][W-1:0];
				end
				c4.fl = o_rs[0][W] | o_rs[1][W] | o_rs[2][W] | o_rs[3][W]
					| ((op_s3 == OP_ROT) && tfl_s3);
			end
			OP_CONJ: begin
				c4.r[0] = a_s3[0];
				for (int k = 1; k < 4; k++) begin
					if ($signed(a_s3[k]) == CMIN_W) begin
						c4.r[k] = CMAX_W;
						c4.fl   = 1'b1;
					end else begin
						c4.r[k] = -a_s3[k];
					end
				end
			end
			OP_SCALE: begin
				for (int k = 0; k < 4; k++) begin
					c4.r[k] = sc_rs[k][W-1:0];
				end
				c4.fl = sc_rs[0][W] | sc_rs[1][W] | sc_rs[2][W] | sc_rs[3][W];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s4  <= c4;
			ss_s4 <= ss_s3;
		end
	end

	// Square root of the sum of squares, one root bit per stage from the top bit down.
	// The remainder is the sum less the square of the root found so far.
	logic                sq_v_s5    [RB];
	item_t               sq_c_s5    [RB];
	logic [RMW-1:0]      sq_rem_s5  [RB];
	logic [RB-1:0]       sq_root_s5 [RB];

	for (genvar j = 0; j < RB; j++) begin : g_sqrt
		localparam int B = RB - 1 - j;

		logic [RMW-1:0] rem_in;
		logic [RMW-1:0] trial;
		logic [RB-1:0]  root_in;
		item_t          c_in;
		logic           v_in;

		if (j == 0) begin : g_first
			assign rem_in  = RMW'(ss_s4);
			assign root_in = '0;
			assign c_in    = c_s4;
			assign v_in    = v_s4;
		end else begin : g_next
			assign rem_in  = sq_rem_s5[j-1];
			assign root_in = sq_root_s5[j-1];
			assign c_in    = sq_c_s5[j-1];
			assign v_in    = sq_v_s5[j-1];
		end

		assign trial = (RMW'(root_in) << (B + 1)) + (RMW'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s5[j] <= 1'b0;
			end else if (en) begin
				sq_v_s5[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_c_s5[j] <= c_in;
				if (rem_in >= trial) begin
					sq_rem_s5[j]  <= rem_in - trial;
					sq_root_s5[j] <= root_in | (RB'(1) << B);
				end else begin
					sq_rem_s5[j]  <= rem_in;
					sq_root_s5[j] <= root_in;
				end
			end
		end
	end

	// Stage 6: the root is rounded to nearest; a remainder above the root means the true
	// root lies above the half step. The magnitude result is finished here.
	logic                v_s6;
	item_t               c_s6;

	logic [RB-1:0]       m6;
	item_t               c6;

	always_comb begin
		m6 = sq_root_s5[RB-1]
			+ RB'(sq_rem_s5[RB-1] > RMW'(sq_root_s5[RB-1]));
		c6   = sq_c_s5[RB-1];
		c6.m = m6;
		if (c6.op == OP_MAG) begin
			c6.fl   = (m6[RB-1:W-1] != '0);
			c6.r[0] = (m6[RB-1:W-1] != '0) ? CMAX_W : m6[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= sq_v_s5[RB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s6 <= c6;
		end
	end

	// Stage 7: the rounding numerator 2*a*2^F + den for each lane, and the divisor 2*|den|.
	// A negative scalar flips the sign of the quotient, which is applied after the division.
	logic                    v_s7;
	item_t                   c_s7;
	logic signed [NW-1:0]    n_s7 [4];
	logic [RB:0]             d_s7;
	logic                    flip_s7;

	logic signed [NW-1:0]    den7;
	logic [RB-1:0]           dabs7;

	always_comb begin
		if (c_s6.op == OP_DIV) begin
			den7  = NW'($signed(c_s6.sc));
			dabs7 = c_s6.sc[W-1] ? RB'(-(RB'($signed(c_s6.sc)))) : RB'(c_s6.sc);
		end else begin
			den7  = NW'($signed({1'b0, c_s6.m}));
			dabs7 = c_s6.m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s7    <= c_s6;
			d_s7    <= {dabs7, 1'b0};
			flip_s7 <= (c_s6.op == OP_DIV) && c_s6.sc[W-1];
			for (int i = 0; i < 4; i++) begin
				n_s7[i] <= (NW'($signed(c_s6.a[i])) <<< (F + 1)) + den7;
			end
		end
	end

	// Stage 8: magnitude and sign of each numerator.
	logic                v_s8;
	item_t               c_s8;
	logic [DW-1:0]       nabs_s8 [4];
	logic [3:0]          neg_s8;
	logic [RB:0]         d_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s8 <= c_s7;
			d_s8 <= d_s7;
			for (int i = 0; i < 4; i++) begin
				neg_s8[i]  <= n_s7[i][NW-1] ^ flip_s7;
				nabs_s8[i] <= n_s7[i][NW-1] ? DW'($unsigned(-n_s7[i]))
					: DW'($unsigned(n_s7[i]));
			end
		end
	end

	// Restoring division, one quotient bit per stage. The first stage tests the bit just
	// above the kept quotient; when it is set the quotient is out of range and clips.
	logic                dv_v_s9   [QB+1];
	item_t               dv_c_s9   [QB+1];
	logic [RB:0]         dv_d_s9   [QB+1];
	logic [3:0]          dv_neg_s9 [QB+1];
	logic [DW-1:0]       dv_rem_s9 [QB+1][4];
	logic [QB:0]         dv_q_s9   [QB+1][4];

	for (genvar j = 0; j <= QB; j++) begin : g_div
		localparam int B = QB - j;

		logic           v_in;
		item_t          c_in;
		logic [RB:0]    d_in;
		logic [3:0]     neg_in;
		logic [DW-1:0]  rem_in [4];
		logic [QB:0]    q_in   [4];
		logic [DW-1:0]  dsh;

		if (j == 0) begin : g_first
			assign v_in   = v_s8;
			assign c_in   = c_s8;
			assign d_in   = d_s8;
			assign neg_in = neg_s8;
			for (genvar i = 0; i < 4; i++) begin : g_lane
				assign rem_in[i] = nabs_s8[i];
				assign q_in[i]   = '0;
			end
		end else begin : g_next
			assign v_in   = dv_v_s9[j-1];
			assign c_in   = dv_c_s9[j-1];
			assign d_in   = dv_d_s9[j-1];
			assign neg_in = dv_neg_s9[j-1];
			for (genvar i = 0; i < 4; i++) begin : g_lane
				assign rem_in[i] = dv_rem_s9[j-1][i];
				assign q_in[i]   = dv_q_s9[j-1][i];
			end
		end

		assign dsh = DW'(d_in) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s9[j] <= 1'b0;
			end else if (en) begin
				dv_v_s9[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_c_s9[j]   <= c_in;
				dv_d_s9[j]   <= d_in;
				dv_neg_s9[j] <= neg_in;
				for (int i = 0; i < 4; i++) begin
					if (rem_in[i] >= dsh) begin
						dv_rem_s9[j][i] <= rem_in[i] - dsh;
						dv_q_s9[j][i]   <= q_in[i] | ((QB + 1)'(1) << B);
					end else begin
						dv_rem_s9[j][i] <= rem_in[i];
						dv_q_s9[j][i]   <= q_in[i];
					end
				end
			end
		end
	end

	// Stage 10: floor of the signed quotient. A negative quotient with a remainder rounds
	// one further down: -(q + 1) is formed as ~q + 0, and -q as ~q + 1.
	logic                v_s10;
	item_t               c_s10;
	logic signed [VW-1:0] val_s10 [4];
	logic [3:0]          ovf_s10;
	logic [3:0]          neg_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= dv_v_s9[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s10   <= dv_c_s9[QB];
			neg_s10 <= dv_neg_s9[QB];
			for (int i = 0; i < 4; i++) begin
				ovf_s10[i] <= dv_q_s9[QB][i][QB];
				if (dv_neg_s9[QB][i]) begin
					val_s10[i] <= ~$signed(VW'(dv_q_s9[QB][i][QB-1:0]))
						+ VW'(dv_rem_s9[QB][i] == '0);
				end else begin
					val_s10[i] <= $signed(VW'(dv_q_s9[QB][i][QB-1:0]));
				end
			end
		end
	end

	// Output register: the divider lanes are clipped and the result is chosen by operation.
	logic [3:0][W-1:0]   lane_r;
	logic [3:0]          lane_f;
	logic [W:0]          lane_sv [4];
	logic [3:0][W-1:0]   fin_r;
	logic                fin_fl;
	logic                fin_dz;

	logic [3:0][W-1:0]   r_q;
	logic                dz_q;
	logic                fl_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lane_sv[i] = sat_v(val_s10[i]);
			if (ovf_s10[i]) begin
				lane_r[i] = neg_s10[i] ? CMIN_W : CMAX_W;
				lane_f[i] = 1'b1;
			end else begin
				lane_r[i] = lane_sv[i][W-1:0];
				lane_f[i] = lane_sv[i][W];
			end
		end

		fin_r  = c_s10.r;
		fin_fl = c_s10.fl;
		fin_dz = 1'b0;
		case (c_s10.op)
			OP_DIV, OP_NORM: begin
				if ((c_s10.op == OP_DIV && c_s10.sc == '0)
					|| (c_s10.op == OP_NORM && c_s10.m == '0)) begin
					fin_r  = '0;
					fin_fl = 1'b0;
					fin_dz = 1'b1;
				end else begin
					fin_r  = lane_r;
					fin_fl = |lane_f;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (en) begin
			vo_q <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q  <= fin_r;
			dz_q <= fin_dz;
			fl_q <= fin_fl;
		end
	end

	assign rsp_valid   = vo_q;
	assign r_w         = r_q[0];
	assign r_x         = r_q[1];
	assign r_y         = r_q[2];
	assign r_z         = r_q[3];
	assign div_by_zero = dz_q;
	assign saturated   = fl_q;

endmodule

@@ rtl/qau_checker.sv @@
`timescale 1ns / 1ps

module qau_checker #(
	parameter int COMP_WIDTH = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_stall,
	input logic                  rsp_valid,
	input logic                  rsp_stall,
	input logic [COMP_WIDTH-1:0] r_w,
	input logic [COMP_WIDTH-1:0] r_x,
	input logic [COMP_WIDTH-1:0] r_y,
	input logic [COMP_WIDTH-1:0] r_z,
	input logic                  div_by_zero,
	input logic                  saturated
);

	// A held result freezes the pipeline, so no request may be taken meanwhile.
	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while a stalled result is held");

	// With the output register empty nothing holds the pipeline.
	a_no_needless_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled with an empty output");

	// A zero divisor or zero magnitude gives a zero result without the clip flag.
	a_zero_divide: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && div_by_zero |-> !saturated && r_w == '0 && r_x == '0
			&& r_y == '0 && r_z == '0)
		else $error("divide by zero result is not clean");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(r_w) && $stable(r_x)
			&& $stable(r_y) && $stable(r_z) && $stable(div_by_zero) && $stable(saturated))
		else $error("stalled result changed");

endmodule

bind quaternion_arithmetic_unit_top qau_checker #(.COMP_WIDTH(COMP_WIDTH)) u_qau_checker (.*);
